// ===== hdl/midi_to_dmx_channel_mapper_top_macros.svh =====
// assertion macros for the midi to dmx mapper
`ifndef MIDI_TO_DMX_CHANNEL_MAPPER_TOP_MACROS_SVH
`define MIDI_TO_DMX_CHANNEL_MAPPER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, masked while reset is high
`define MDM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked property, also during reset
`define MDM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MDM_ASSERT(label, prop, msg)
`define MDM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/mdm_pkg.sv =====
package mdm_pkg;

   // defaults for the top level parameters
   localparam int STORE_DEPTH_DEF     = 512;
   localparam int MAPPED_CHANNELS_DEF = 4;
   localparam int SLOTS_PER_CHANNEL   = 128;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int DATA_W  = 7;
   localparam int CH_W    = 2;
   localparam int ADDR_W  = 9;
   localparam int LEVEL_W = 8;
   localparam int FRAME_W = 10;
   localparam int MODE_W  = 7;

   // midi byte codes
   localparam logic [7:0] SYS_RESET    = 8'hFF;
   localparam logic [7:0] RT_FIRST     = 8'hF8;
   localparam logic [7:0] SYSEX_END    = 8'hF7;
   localparam logic [7:0] SYSEX_START  = 8'hF0;
   localparam logic [7:0] STATUS_RESET = 8'h80;
   localparam logic [3:0] KIND_PROG     = 4'hC;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_TOUCH    = 4'hA;
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

   // message sizes by status
   localparam logic [1:0] SYS_SIZE  [8] = '{2'd0, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd0};
   localparam logic [1:0] CHAN_SIZE [8] = '{2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3};

   // operations handed from the parser to the execute stage
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_PROG  = 3'd1;
   localparam logic [2:0] OP_ON    = 3'd2;
   localparam logic [2:0] OP_OFF   = 3'd3;
   localparam logic [2:0] OP_TOUCH = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   // channel modes that enable level writes
   localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 7'd1;
   localparam logic [MODE_W-1:0] MODE_TOUCH_A  = 7'd2;
   localparam logic [MODE_W-1:0] MODE_TOUCH_B  = 7'd3;

   typedef struct packed {
      logic [2:0]        op;
      logic [CH_W-1:0]   ch;
      logic [DATA_W-1:0] d1;
      logic [DATA_W-1:0] d2;
   } exec_type;

   function automatic logic [1:0] msg_size(input logic [7:0] st);
      logic [1:0] sz;
      if (st >= SYSEX_START) begin
         sz = SYS_SIZE[st[2:0]];
      end else begin
         sz = CHAN_SIZE[st[6:4]];
      end
      return sz;
   endfunction

endpackage

// ===== hdl/mdm_parser.sv =====
module mdm_parser #(
   parameter int MAPPED_CHANNELS = mdm_pkg::MAPPED_CHANNELS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                midi_byte,
   output mdm_pkg::exec_type         exec_cmd
);

   logic [7:0]                 rs_ff, rs_in;
   logic [7:0]                 mb0_ff, mb0_in;
   logic [mdm_pkg::DATA_W-1:0] mb1_ff, mb1_in;
   logic [mdm_pkg::DATA_W-1:0] mb2_ff, mb2_in;
   logic [1:0]                 len_ff, len_in;
   logic                       sysex_ff, sysex_in;

   logic [7:0]                 n0;
   logic [mdm_pkg::DATA_W-1:0] n1, n2;
   logic [1:0]                 nlen;
   logic [1:0]                 size;
   mdm_pkg::exec_type          cmd;

   // byte parser with running status
   always_comb begin
      rs_in    = rs_ff;
      mb0_in   = mb0_ff;
      mb1_in   = mb1_ff;
      mb2_in   = mb2_ff;
      len_in   = len_ff;
      sysex_in = sysex_ff;
      n0       = mb0_ff;
      n1       = mb1_ff;
      n2       = mb2_ff;
      nlen     = len_ff;
      size     = '0;
      cmd      = '0;
      cmd.op   = mdm_pkg::OP_NONE;
      priority if (midi_byte == mdm_pkg::SYS_RESET) begin
         rs_in    = mdm_pkg::STATUS_RESET;
         mb0_in   = '0;
         mb1_in   = '0;
         mb2_in   = '0;
         len_in   = '0;
         sysex_in = 1'b0;
         cmd.op   = mdm_pkg::OP_CLEAR;
      end else if (midi_byte >= mdm_pkg::RT_FIRST) begin
         // real-time bytes leave everything alone
      end else if (sysex_ff) begin
         if (midi_byte == mdm_pkg::SYSEX_END) begin
            sysex_in = 1'b0;
         end
      end else if (midi_byte == mdm_pkg::SYSEX_START) begin
         sysex_in = 1'b1;
         len_in   = '0;
      end else begin
         // append the byte to the message
         priority if (midi_byte[7]) begin
            rs_in = midi_byte;
            n0    = midi_byte;
            nlen  = 2'd1;
         end else if (len_ff == 2'd0) begin
            n0   = rs_ff;
            n1   = midi_byte[mdm_pkg::DATA_W-1:0];
            nlen = 2'd2;
         end else if (len_ff == 2'd1) begin
            n1   = midi_byte[mdm_pkg::DATA_W-1:0];
            nlen = 2'd2;
         end else begin
            n2   = midi_byte[mdm_pkg::DATA_W-1:0];
            nlen = 2'd3;
         end
         mb0_in = n0;
         mb1_in = n1;
         mb2_in = n2;
         len_in = nlen;
         size   = mdm_pkg::msg_size(n0);
         // message complete
         if (nlen >= size) begin
            len_in = '0;
            if (nlen == size && n0 < mdm_pkg::SYSEX_START &&
                n0[3:0] < 4'(MAPPED_CHANNELS)) begin
               cmd.ch = n0[mdm_pkg::CH_W-1:0];
               cmd.d1 = n1;
               cmd.d2 = n2;
               priority if (n0[7:4] == mdm_pkg::KIND_PROG) begin
                  cmd.op = mdm_pkg::OP_PROG;
               end else if (n0[7:4] == mdm_pkg::KIND_NOTE_ON) begin
                  cmd.op = mdm_pkg::OP_ON;
               end else if (n0[7:4] == mdm_pkg::KIND_NOTE_OFF) begin
                  cmd.op = mdm_pkg::OP_OFF;
               end else if (n0[7:4] == mdm_pkg::KIND_TOUCH) begin
                  cmd.op = mdm_pkg::OP_TOUCH;
               end else begin
                  cmd.op = mdm_pkg::OP_NONE;
               end
            end
         end
      end
   end

   assign exec_cmd = cmd;

   // parser state, updated on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff    <= mdm_pkg::STATUS_RESET;
         mb0_ff   <= '0;
         mb1_ff   <= '0;
         mb2_ff   <= '0;
         len_ff   <= '0;
         sysex_ff <= 1'b0;
      end else if (accept) begin
         rs_ff    <= rs_in;
         mb0_ff   <= mb0_in;
         mb1_ff   <= mb1_in;
         mb2_ff   <= mb2_in;
         len_ff   <= len_in;
         sysex_ff <= sysex_in;
      end
   end

endmodule

// ===== hdl/midi_to_dmx_channel_mapper_top.sv =====
// a result passes through the execute register and then the output register
// no new input byte is taken while the execute stage still holds one
// reset and the 0xff byte start a clearing pass that zeroes every address of
// the level store (STORE_DEPTH, 512 by default), during which no input byte is taken
// results already queued are still delivered during the pass
module midi_to_dmx_channel_mapper_top #(
   parameter int STORE_DEPTH     = mdm_pkg::STORE_DEPTH_DEF,
   parameter int MAPPED_CHANNELS = mdm_pkg::MAPPED_CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mdm_pkg::BYTE_W-1:0]   req_midi_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_write_valid,
   output logic [mdm_pkg::ADDR_W-1:0]   rsp_write_address,
   output logic [mdm_pkg::LEVEL_W-1:0]  rsp_write_value,
   output logic [mdm_pkg::FRAME_W-1:0]  rsp_frame_channels,
   output logic                         rsp_store_cleared
);

   `include "midi_to_dmx_channel_mapper_top_macros.svh"

   localparam int AW      = $clog2(STORE_DEPTH);
   localparam int MODE_IW = (MAPPED_CHANNELS > 1) ? $clog2(MAPPED_CHANNELS) : 1;

   // memories
   logic [mdm_pkg::LEVEL_W-1:0] level_mem [STORE_DEPTH];
   logic [mdm_pkg::MODE_W-1:0]  mode_mem  [MAPPED_CHANNELS];

   logic                        req_accept;
   logic                        rsp_free;
   logic                        ex_done;
   mdm_pkg::exec_type           cmd;

   logic                        ex_vld_ff;
   mdm_pkg::exec_type           ex_ff;
   logic [mdm_pkg::MODE_W-1:0]  mode_rd_ff;
   logic [MAPPED_CHANNELS-1:0]  mode_vld_ff;
   logic [MAPPED_CHANNELS-1:0]  mask_ff, mask_in;
   logic                        sweep_ff;
   logic [AW-1:0]               sweep_addr_ff;

   logic                        rsp_valid_ff;
   logic                        rsp_wv_ff;
   logic [mdm_pkg::ADDR_W-1:0]  rsp_addr_ff;
   logic [mdm_pkg::LEVEL_W-1:0] rsp_val_ff;
   logic [mdm_pkg::FRAME_W-1:0] rsp_frame_ff, frame_in;
   logic                        rsp_clr_ff;

   logic [MODE_IW-1:0]          ex_idx;
   logic [mdm_pkg::MODE_W-1:0]  mode_cur;
   logic                        wr;
   logic                        wv;
   logic [mdm_pkg::LEVEL_W-1:0] val;
   logic [mdm_pkg::ADDR_W-1:0]  addr;
   logic                        in_store;
   logic                        cleared;

   // handshake
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = sweep_ff || ex_vld_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign ex_done    = ex_vld_ff && rsp_free;

   mdm_parser #(
      .MAPPED_CHANNELS (MAPPED_CHANNELS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .midi_byte (req_midi_byte),
      .exec_cmd  (cmd)
   );

   // execute: apply the command with the mode read from memory
   assign ex_idx = ex_ff.ch[MODE_IW-1:0];

   always_comb begin
      mode_cur = mode_vld_ff[ex_idx] ? mode_rd_ff : '0;
      wr       = 1'b0;
      val      = '0;
      mask_in  = mask_ff;
      cleared  = 1'b0;
      unique case (ex_ff.op)
         mdm_pkg::OP_PROG: begin
            mask_in[ex_idx] = (ex_ff.d1 != '0);
         end
         mdm_pkg::OP_ON: begin
            wr  = 1'b1;
            val = {ex_ff.d2, 1'b1};
         end
         mdm_pkg::OP_OFF: begin
            wr  = (mode_cur == mdm_pkg::MODE_NOTE_OFF);
            val = {ex_ff.d2, 1'b0};
         end
         mdm_pkg::OP_TOUCH: begin
            wr  = (mode_cur == mdm_pkg::MODE_TOUCH_A) || (mode_cur == mdm_pkg::MODE_TOUCH_B);
            val = {ex_ff.d2, 1'b0};
         end
         mdm_pkg::OP_CLEAR: begin
            mask_in = '0;
            cleared = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign addr     = {ex_ff.ch, ex_ff.d1};
   assign in_store = {1'b0, addr} < 10'(STORE_DEPTH);
   assign wv       = wr && in_store;

   // active slot count from the highest channel with a nonzero mode
   always_comb begin
      frame_in = '0;
      for (int c = 0; c < MAPPED_CHANNELS; c++) begin
         if (mask_in[c]) begin
            frame_in = mdm_pkg::FRAME_W'((c + 1) * mdm_pkg::SLOTS_PER_CHANNEL);
         end
      end
      if (frame_in > mdm_pkg::FRAME_W'(STORE_DEPTH)) begin
         frame_in = mdm_pkg::FRAME_W'(STORE_DEPTH);
      end
   end

   // level store write port: clearing pass or execute write
   always_ff @(posedge clock) begin
      if (sweep_ff) begin
         level_mem[sweep_addr_ff] <= '0;
      end else if (ex_done && wv) begin
         level_mem[addr[AW-1:0]] <= val;
      end
   end

   // mode memory: read on input transfer, write on program change
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_rd_ff <= mode_mem[cmd.ch[MODE_IW-1:0]];
      end
      if (ex_done && ex_ff.op == mdm_pkg::OP_PROG) begin
         mode_mem[ex_idx] <= ex_ff.d1;
      end
   end

   // execute stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ex_ff <= cmd;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff     <= 1'b0;
         mode_vld_ff   <= '0;
         mask_ff       <= '0;
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // execute stage occupancy
         if (req_accept) begin
            ex_vld_ff <= 1'b1;
         end else if (ex_done) begin
            ex_vld_ff <= 1'b0;
         end
         // clearing pass
         if (sweep_ff) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == AW'(STORE_DEPTH - 1)) begin
               sweep_ff <= 1'b0;
            end
         end
         // mode bookkeeping
         if (ex_done) begin
            mask_ff <= mask_in;
            if (ex_ff.op == mdm_pkg::OP_PROG) begin
               mode_vld_ff[ex_idx] <= 1'b1;
            end else if (ex_ff.op == mdm_pkg::OP_CLEAR) begin
               mode_vld_ff   <= '0;
               sweep_ff      <= 1'b1;
               sweep_addr_ff <= '0;
            end
         end
         // output register
         if (ex_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (ex_done) begin
         rsp_wv_ff    <= wv;
         rsp_addr_ff  <= wv ? addr : '0;
         rsp_val_ff   <= wv ? val : '0;
         rsp_frame_ff <= frame_in;
         rsp_clr_ff   <= cleared;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_valid    = rsp_wv_ff;
   assign rsp_write_address  = rsp_addr_ff;
   assign rsp_write_value    = rsp_val_ff;
   assign rsp_frame_channels = rsp_frame_ff;
   assign rsp_store_cleared  = rsp_clr_ff;

   // assertions
   `MDM_ASSERT(a_sweep_excl, !(sweep_ff && ex_vld_ff), "clearing pass overlaps execute")
   `MDM_ASSERT(a_exec_to_rsp, ex_done |=> rsp_valid_ff, "finished item missing from output")
   `MDM_ASSERT(a_addr_range, (rsp_valid_ff && rsp_wv_ff) |-> ({1'b0, rsp_addr_ff} < 10'(STORE_DEPTH)), "write past store")
   `MDM_ASSERT(a_idle_zero, (rsp_valid_ff && !rsp_wv_ff) |-> (rsp_addr_ff == '0 && rsp_val_ff == '0), "idle write not zero")
   `MDM_ASSERT(a_clear_frame, (rsp_valid_ff && rsp_clr_ff) |-> (rsp_frame_ff == '0), "clear without reset of count")

endmodule

// ===== dv/midi_to_dmx_channel_mapper_top_test.sv =====
`timescale 1ns / 1ps

module midi_to_dmx_channel_mapper_top_test;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS = 10;
   localparam logic [7:0] TUNE_REQUEST = 8'hF6;
   localparam logic [3:0] KIND_PRESSURE = 4'hD;
   localparam logic [3:0] KIND_BEND = 4'hE;

   typedef struct packed {
      logic                        write_valid;
      logic [mdm_pkg::ADDR_W-1:0]  write_address;
      logic [mdm_pkg::LEVEL_W-1:0] write_value;
      logic [mdm_pkg::FRAME_W-1:0] frame_channels;
      logic                        store_cleared;
   } level_write_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [mdm_pkg::BYTE_W-1:0]  req_midi_byte = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_write_valid;
   logic [mdm_pkg::ADDR_W-1:0]  rsp_write_address;
   logic [mdm_pkg::LEVEL_W-1:0] rsp_write_value;
   logic [mdm_pkg::FRAME_W-1:0] rsp_frame_channels;
   logic                        rsp_store_cleared;

   // parser and mode state as the block should hold it
   logic [mdm_pkg::MODE_W-1:0]  mode_of_channel [mdm_pkg::MAPPED_CHANNELS_DEF];
   logic [7:0]                  status_held;
   logic [7:0]                  msg_held [3];
   int                          msg_count;
   logic                        skipping_sysex;
   logic [mdm_pkg::FRAME_W-1:0] slots_active;
   logic                        byte_was_ignored;

   level_write_type writes_due [$];
   int idle_pct = 18;
   int bytes_used = 0;
   int mismatches = 0;
   int cycle_count = 0;

   midi_to_dmx_channel_mapper_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_midi_byte      (req_midi_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_address  (rsp_write_address),
      .rsp_write_value    (rsp_write_value),
      .rsp_frame_channels (rsp_frame_channels),
      .rsp_store_cleared  (rsp_store_cleared)
   );

   // clock
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** midi_to_dmx_channel_mapper_top: FAILED **");
         $finish;
      end
   end

   // back to the power-up state
   function automatic void clear_parser();
      foreach (mode_of_channel[c]) mode_of_channel[c] = '0;
      status_held = mdm_pkg::STATUS_RESET;
      foreach (msg_held[i]) msg_held[i] = '0;
      msg_count = 0;
      skipping_sysex = 1'b0;
      slots_active = '0;
   endfunction

   // bytes a message takes, status included
   function automatic int message_size(input logic [7:0] st);
      int sz;
      if (st >= mdm_pkg::SYSEX_START) begin
         case (st[2:0])
            3'd1, 3'd3: sz = 2;
            3'd2: sz = 3;
            3'd4, 3'd5, 3'd6: sz = 1;
            default: sz = 0;
         endcase
      end else if (st[6:4] == 3'd4 || st[6:4] == 3'd5) begin
         sz = 2;
      end else begin
         sz = 3;
      end
      return sz;
   endfunction

   // highest channel with a nonzero mode sets the frame length
   function automatic void count_slots();
      int n;
      n = 0;
      for (int c = 0; c < mdm_pkg::MAPPED_CHANNELS_DEF; c++) begin
         if (mode_of_channel[c] != '0) n = (c + 1) * mdm_pkg::SLOTS_PER_CHANNEL;
      end
      if (n > mdm_pkg::STORE_DEPTH_DEF) n = mdm_pkg::STORE_DEPTH_DEF;
      slots_active = mdm_pkg::FRAME_W'(n);
   endfunction

   // result of one midi byte, state updated
   function automatic level_write_type parse_midi_byte(input logic [7:0] b);
      level_write_type r;
      int sz;
      int len;
      logic [7:0] st;
      logic [3:0] kind;
      logic [3:0] ch;
      logic [mdm_pkg::DATA_W-1:0] d1;
      logic [mdm_pkg::DATA_W-1:0] d2;
      logic [mdm_pkg::MODE_W-1:0] mode;
      logic wr;
      r = '0;
      wr = 1'b0;
      byte_was_ignored = 1'b0;
      if (b == mdm_pkg::SYS_RESET) begin
         clear_parser();
         r.store_cleared = 1'b1;
      end else if (b >= mdm_pkg::RT_FIRST) begin
         byte_was_ignored = 1'b1;
      end else if (skipping_sysex) begin
         byte_was_ignored = (b != mdm_pkg::SYSEX_END);
         if (b == mdm_pkg::SYSEX_END) skipping_sysex = 1'b0;
      end else if (b == mdm_pkg::SYSEX_START) begin
         skipping_sysex = 1'b1;
         msg_count = 0;
      end else begin
         if (b[7]) begin
            status_held = b;
            msg_held[0] = b;
            msg_count = 1;
         end else if (msg_count == 0) begin
            msg_held[0] = status_held;
            msg_held[1] = b;
            msg_count = 2;
         end else begin
            msg_held[msg_count] = b;
            msg_count++;
         end
         st = msg_held[0];
         sz = message_size(st);
         if (msg_count >= sz) begin
            len = msg_count;
            msg_count = 0;
            kind = st[7:4];
            ch = st[3:0];
            if (len == sz && st < mdm_pkg::SYSEX_START &&
                ch < mdm_pkg::MAPPED_CHANNELS_DEF) begin
               d1 = msg_held[1][mdm_pkg::DATA_W-1:0];
               d2 = msg_held[2][mdm_pkg::DATA_W-1:0];
               mode = mode_of_channel[ch];
               if (kind == mdm_pkg::KIND_PROG) begin
                  mode_of_channel[ch] = d1;
                  count_slots();
               end else if (kind == mdm_pkg::KIND_NOTE_ON) begin
                  r.write_value = {d2, 1'b1};
                  wr = 1'b1;
               end else if ((kind == mdm_pkg::KIND_NOTE_OFF &&
                             mode == mdm_pkg::MODE_NOTE_OFF) ||
                            (kind == mdm_pkg::KIND_TOUCH &&
                             (mode == mdm_pkg::MODE_TOUCH_A ||
                              mode == mdm_pkg::MODE_TOUCH_B))) begin
                  r.write_value = {d2, 1'b0};
                  wr = 1'b1;
               end
               if (wr && ch * mdm_pkg::SLOTS_PER_CHANNEL + d1 < mdm_pkg::STORE_DEPTH_DEF) begin
                  r.write_valid = 1'b1;
                  r.write_address =
                     mdm_pkg::ADDR_W'(ch * mdm_pkg::SLOTS_PER_CHANNEL + d1);
               end else begin
                  r.write_value = '0;
               end
            end
         end
      end
      r.frame_channels = slots_active;
      return r;
   endfunction

   // one byte over the request channel, then its expected result
   task automatic send_midi_byte(input logic [7:0] b);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_midi_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      writes_due.push_back(parse_midi_byte(b));
      if (!byte_was_ignored) bytes_used++;
   endtask

   // sender holds off until every result is in
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
   endtask

   // note, program, aftertouch, sysex and status corner cases
   task automatic test_directed_messages();
      logic [7:0] seq [$];
      seq = '{{mdm_pkg::KIND_NOTE_ON, 4'd0}, 8'h00, 8'h00,
              {mdm_pkg::KIND_PROG, 4'd3}, 8'h01,
              {mdm_pkg::KIND_NOTE_OFF, 4'd3}, 8'h05, 8'h40,
              {mdm_pkg::KIND_PROG, 4'd2}, 8'h02,
              {mdm_pkg::KIND_TOUCH, 4'd2}, 8'h10, 8'h20,
              mdm_pkg::SYSEX_START, 8'h12, mdm_pkg::RT_FIRST, mdm_pkg::SYSEX_END,
              {mdm_pkg::KIND_NOTE_ON, 4'd0}, 8'h05,
              {mdm_pkg::KIND_NOTE_ON, 4'd1}, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
              {mdm_pkg::KIND_NOTE_ON, 4'hF}, 8'h01, 8'h02,
              mdm_pkg::SYSEX_END,
              TUNE_REQUEST, 8'h22,
              mdm_pkg::SYS_RESET};
      foreach (seq[i]) send_midi_byte(seq[i]);
      wait_for_results();
   endtask

   // one channel message, sometimes on running status or cut short
   task automatic send_channel_message();
      logic [3:0] ch;
      logic [3:0] kind;
      logic [7:0] d1;
      logic [7:0] d2;
      ch = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      kind = 4'($urandom_range(mdm_pkg::KIND_NOTE_OFF, KIND_BEND));
      d1 = 8'($urandom_range(127));
      d2 = ($urandom_range(7) == 0) ? {1'b0, {7{d1[0]}}} : 8'($urandom_range(127));
      if (kind == mdm_pkg::KIND_PROG && $urandom_range(9) < 7) d1 = 8'($urandom_range(3));
      if ($urandom_range(3) != 0) send_midi_byte({kind, ch});
      send_midi_byte(d1);
      if (kind != mdm_pkg::KIND_PROG && kind != KIND_PRESSURE && $urandom_range(19) != 0)
         send_midi_byte(d2);
   endtask

   // sysex block with data, real-time bytes and system resets inside
   task automatic send_sysex_block();
      int n;
      n = $urandom_range(6);
      send_midi_byte(mdm_pkg::SYSEX_START);
      repeat (n) begin
         case ($urandom_range(19))
            0: send_midi_byte(8'($urandom_range(mdm_pkg::RT_FIRST, mdm_pkg::SYS_RESET - 1)));
            1: send_midi_byte(mdm_pkg::SYS_RESET);
            default: send_midi_byte(8'($urandom_range(127)));
         endcase
      end
      if ($urandom_range(19) != 0) send_midi_byte(mdm_pkg::SYSEX_END);
   endtask

   // mostly well-formed messages, some sysex, noise and system resets
   task automatic send_midi_traffic(input int n_bytes);
      int start;
      int pick;
      start = bytes_used;
      while (bytes_used - start < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 72) send_channel_message();
         else if (pick < 80) send_sysex_block();
         else if (pick < 98) send_midi_byte(8'($urandom_range(mdm_pkg::SYS_RESET - 1)));
         else send_midi_byte(mdm_pkg::SYS_RESET);
      end
   endtask

   task automatic test_back_to_back();
      idle_pct = 0;
      send_midi_traffic(200);
      wait_for_results();
      idle_pct = 18;
   endtask

   task automatic test_random_traffic();
      send_midi_traffic(650);
      wait_for_results();
   endtask

   task automatic note_mismatch(input string what, input level_write_type exp_r);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t %s: exp wv=%0d addr=%0d val=%0d frame=%0d clr=%0d",
                  $time, what, exp_r.write_valid, exp_r.write_address,
                  exp_r.write_value, exp_r.frame_channels, exp_r.store_cleared);
         $display("   got wv=%0d addr=%0d val=%0d frame=%0d clr=%0d",
                  rsp_write_valid, rsp_write_address, rsp_write_value,
                  rsp_frame_channels, rsp_store_cleared);
      end
   endtask

   // result side stall
   always @(negedge clock) begin
      rsp_stall <= (idle_pct != 0 && $urandom_range(99) < idle_pct);
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : check_results
      level_write_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (writes_due.size() == 0) begin
            note_mismatch("unexpected result", '0);
         end else begin
            exp_r = writes_due.pop_front();
            if (rsp_write_valid !== exp_r.write_valid ||
                rsp_write_address !== exp_r.write_address ||
                rsp_write_value !== exp_r.write_value ||
                rsp_frame_channels !== exp_r.frame_channels ||
                rsp_store_cleared !== exp_r.store_cleared) begin
               note_mismatch("result mismatch", exp_r);
            end
         end
      end
   end

   initial begin
      clear_parser();
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_directed_messages();
      test_back_to_back();
      test_random_traffic();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (writes_due.size() != 0) note_mismatch("result never came", writes_due[0]);
      if (mismatches == 0) begin
         $display("** midi_to_dmx_channel_mapper_top: PASSED **");
      end else begin
         $display("** midi_to_dmx_channel_mapper_top: FAILED **");
      end
      $finish;
   end

endmodule
